/* design/vertical_gaussian_clamped_filter_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the vertical Gaussian filter
// Shared property forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VERTICAL_GAUSSIAN_CLAMPED_FILTER_ASSERT_SVH
`define VERTICAL_GAUSSIAN_CLAMPED_FILTER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define VGCF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vgcf: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define VGCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vgcf: next-cycle check failed");

`endif

/* design/vgcf_pkg.sv */
// ---------------------------------------------------------------------------
// Vertical Gaussian filter package
// Sizes, control types and controller states shared by the controller, the datapath and the top level.
// ---------------------------------------------------------------------------
package vgcf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_SPAN    = 11;
  localparam int SLOTS       = 2 * MAX_SPAN;
  localparam int STORE_DEPTH = SLOTS * MAX_WIDTH;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ADDR_W      = SLOT_W + COL_W;
  localparam int PIX_W       = 16;
  localparam int ROW_W       = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int ACC_W       = 37;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_FIN,
    ST_OUT,
    ST_ADV
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic write;
    logic first_out;
    logic rd;
    logic mul;
    logic acc;
    logic next_tap;
    logic fin;
    logic next_out;
    logic adv;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic none_out;
    logic last_tap;
    logic last_out;
  } status_t;

endpackage

/* design/vgcf_ram.sv */
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module vgcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Storage array with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/vgcf_ctrl.sv */
// ---------------------------------------------------------------------------
// Vertical Gaussian filter controller
// Sequences write, tap reads, multiply-accumulate and result handoff.
// ---------------------------------------------------------------------------
module vgcf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  vgcf_pkg::status_t sts,
  output vgcf_pkg::cmd_t    cmd
);

  vgcf_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vgcf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      vgcf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = vgcf_pkg::ST_WRITE;
        end
      end
      vgcf_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        if (sts.none_out) begin
          state_nxt = vgcf_pkg::ST_ADV;
        end else begin
          cmd.first_out = 1'b1;
          state_nxt     = vgcf_pkg::ST_READ;
        end
      end
      vgcf_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = vgcf_pkg::ST_MUL;
      end
      vgcf_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = vgcf_pkg::ST_ACC;
      end
      vgcf_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last_tap) begin
          state_nxt = vgcf_pkg::ST_FIN;
        end else begin
          cmd.next_tap = 1'b1;
          state_nxt    = vgcf_pkg::ST_READ;
        end
      end
      vgcf_pkg::ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = vgcf_pkg::ST_OUT;
      end
      vgcf_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.last_out) begin
            state_nxt = vgcf_pkg::ST_ADV;
          end else begin
            cmd.next_out = 1'b1;
            state_nxt    = vgcf_pkg::ST_READ;
          end
        end
      end
      vgcf_pkg::ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = vgcf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vgcf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/vgcf_datapath.sv */
// ---------------------------------------------------------------------------
// Vertical Gaussian filter datapath
// Configuration, position counters, line store and one shared MAC.
// ---------------------------------------------------------------------------
module vgcf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vgcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vgcf_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic [vgcf_pkg::PIX_W-1:0]          in_pixel_in,
  input  vgcf_pkg::cmd_t                      cmd,
  output vgcf_pkg::status_t                   sts,
  output logic [vgcf_pkg::PIX_W-1:0]          out_pixel_out,
  output logic [vgcf_pkg::ROW_W-1:0]          out_row,
  output logic [vgcf_pkg::COL_W-1:0]          out_col,
  output logic                                out_last_of_run,
  output logic                                out_last_of_frame
);

  localparam int ROW_W  = vgcf_pkg::ROW_W;
  localparam int COL_W  = vgcf_pkg::COL_W;
  localparam int SLOT_W = vgcf_pkg::SLOT_W;
  localparam int PIX_W  = vgcf_pkg::PIX_W;
  localparam int ACC_W  = vgcf_pkg::ACC_W;

  // Configuration registers.
  logic [11:0]                width_r;
  logic [15:0]                height_r;
  logic [3:0]                 span_cfg_r;
  logic [vgcf_pkg::CFG_W-1:0] coef_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= 12'd640;
      height_r   <= 16'd480;
      span_cfg_r <= 4'd4;
      coef_r[0]  <= '0;
      coef_r[1]  <= '0;
      coef_r[2]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgcf_pkg::REG_WIDTH:  width_r    <= cfg_wdata[11:0];
        vgcf_pkg::REG_HEIGHT: height_r   <= cfg_wdata[15:0];
        vgcf_pkg::REG_SPAN:   span_cfg_r <= cfg_wdata[3:0];
        vgcf_pkg::REG_COEF0:  coef_r[0]  <= cfg_wdata;
        vgcf_pkg::REG_COEF1:  coef_r[1]  <= cfg_wdata;
        vgcf_pkg::REG_COEF2:  coef_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective sizes: width clamped to the store, height and span bounded.
  logic [11:0] w_eff;
  logic [15:0] h_eff;
  logic [3:0]  span;

  always_comb begin
    if (width_r == '0) begin
      w_eff = 12'd1;
    end else if (width_r > 12'(vgcf_pkg::MAX_WIDTH)) begin
      w_eff = 12'(vgcf_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? 16'd1 : height_r;
    span  = (span_cfg_r > 4'(vgcf_pkg::MAX_SPAN)) ? 4'(vgcf_pkg::MAX_SPAN) : span_cfg_r;
  end

  // Position of the next pixel; the slot tracks the row modulo the store rows.
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] slot_r;

  // Position of the pixel being worked on.
  logic [COL_W-1:0]  c_r;
  logic [ROW_W-1:0]  y_r;
  logic [SLOT_W-1:0] ys_r;
  logic [PIX_W-1:0]  pix_r;
  logic              lastrow_r;
  logic              eol_r;

  logic [COL_W-1:0]  c_n;
  logic [ROW_W-1:0]  y_n;
  logic [SLOT_W-1:0] ys_n;
  logic              row_wrap;

  always_comb begin
    c_n      = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    row_wrap = (row_r >= h_eff);
    y_n      = row_wrap ? '0 : row_r;
    ys_n     = row_wrap ? '0 : slot_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_r       <= c_n;
      y_r       <= y_n;
      ys_r      <= ys_n;
      pix_r     <= in_pixel_in;
      lastrow_r <= ({1'b0, y_n} + 17'd1) == {1'b0, h_eff};
      eol_r     <= ({1'b0, c_n} + 12'd1) == w_eff;
    end
  end

  // Counter advance after the item is done.
  logic [ROW_W:0] y_inc;
  assign y_inc = {1'b0, y_r} + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (cmd.adv) begin
      if (eol_r) begin
        col_r <= '0;
        if (y_inc >= {1'b0, h_eff}) begin
          row_r  <= '0;
          slot_r <= '0;
        end else begin
          row_r  <= y_inc[ROW_W-1:0];
          slot_r <= (ys_r == SLOT_W'(vgcf_pkg::SLOTS - 1)) ? '0 : ys_r + 1'b1;
        end
      end else begin
        col_r <= c_r + 1'b1;
      end
    end
  end

  // Output row and tap position; side low selects the row above.
  logic [ROW_W-1:0] o_r;
  logic [3:0]       k_r;
  logic             side_r;
  logic [ROW_W-1:0] o_first;

  assign o_first = ({12'd0, span} <= y_r) ? y_r - {12'd0, span} : '0;

  always_ff @(posedge clk) begin
    if (cmd.first_out) begin
      o_r    <= o_first;
      k_r    <= '0;
      side_r <= 1'b0;
    end else if (cmd.next_out) begin
      o_r    <= o_r + 1'b1;
      k_r    <= '0;
      side_r <= 1'b0;
    end else if (cmd.next_tap) begin
      if (k_r == '0) begin
        k_r    <= 4'd1;
        side_r <= 1'b0;
      end else if (!side_r) begin
        side_r <= 1'b1;
      end else begin
        k_r    <= k_r + 1'b1;
        side_r <= 1'b0;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.none_out = !lastrow_r && ({12'd0, span} > y_r);
    sts.last_tap = (k_r == span) && ((k_r == '0) || side_r);
    sts.last_out = !lastrow_r || (o_r == y_r);
  end

  // Tap row with clamp to the frame edges, then its slot in the store.
  logic [ROW_W-1:0]  up_row;
  logic [ROW_W:0]    dn_sum;
  logic [ROW_W-1:0]  dn_row;
  logic [ROW_W-1:0]  tap_row;
  logic [SLOT_W-1:0] diff;
  logic [SLOT_W:0]   slot_tmp;
  logic [SLOT_W-1:0] tap_slot;

  always_comb begin
    up_row   = (o_r >= {12'd0, k_r}) ? o_r - {12'd0, k_r} : '0;
    dn_sum   = {1'b0, o_r} + {13'd0, k_r};
    dn_row   = (dn_sum <= {1'b0, y_r}) ? dn_sum[ROW_W-1:0] : y_r;
    if (k_r == '0) begin
      tap_row = o_r;
    end else if (side_r) begin
      tap_row = dn_row;
    end else begin
      tap_row = up_row;
    end
    diff     = SLOT_W'(y_r - tap_row);
    slot_tmp = {1'b0, ys_r} + (SLOT_W + 1)'(vgcf_pkg::SLOTS) - {1'b0, diff};
    tap_slot = (slot_tmp >= (SLOT_W + 1)'(vgcf_pkg::SLOTS))
             ? SLOT_W'(slot_tmp - (SLOT_W + 1)'(vgcf_pkg::SLOTS))
             : slot_tmp[SLOT_W-1:0];
  end

  // Line store.
  logic [PIX_W-1:0] rd_data;

  vgcf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (vgcf_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.write),
    .wr_addr ({ys_r, c_r}),
    .wr_data (pix_r),
    .rd_en   (cmd.rd),
    .rd_addr ({tap_slot, c_r}),
    .rd_data (rd_data)
  );

  // Coefficient of the current tap.
  logic [15:0] coef_k;

  always_comb begin
    unique case (k_r[3:2])
      2'd0:    coef_k = coef_r[0][{k_r[1:0], 4'd0} +: 16];
      2'd1:    coef_k = coef_r[1][{k_r[1:0], 4'd0} +: 16];
      2'd2:    coef_k = coef_r[2][{k_r[1:0], 4'd0} +: 16];
      default: coef_k = '0;
    endcase
  end

  // Multiply, then accumulate.
  logic [31:0]      prod_r;
  logic [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= rd_data * coef_k;
    end
    if (cmd.first_out || cmd.next_out) begin
      acc_r <= '0;
    end else if (cmd.acc) begin
      acc_r <= acc_r + {5'd0, prod_r};
    end
  end

  // Round half up from Q.15, saturate, and hold the result word.
  logic [ACC_W:0]   rnd;
  logic [ACC_W-15:0] shifted;

  assign rnd     = {1'b0, acc_r} + (ACC_W + 1)'(16384);
  assign shifted = rnd[ACC_W:15];

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_pixel_out     <= (shifted > (ACC_W - 14)'(65535)) ? 16'hFFFF : shifted[15:0];
      out_row           <= o_r;
      out_col           <= c_r;
      out_last_of_run   <= sts.last_out;
      out_last_of_frame <= lastrow_r && (o_r == y_r) && eol_r;
    end
  end

endmodule

/* design/vertical_gaussian_clamped_filter.sv */
// ---------------------------------------------------------------------------
// Vertical Gaussian filter, clamp-to-edge rows
// Top level: controller, datapath with line store, and port checks.
// ---------------------------------------------------------------------------
// Takes one Q0.16 pixel word at a time in raster order and returns the
// vertically blurred word of the row half_span above it (the last row of a
// frame returns every row still open in its column, top first). The block
// takes no new word until the last one is done: each result costs a read, a
// multiply and an add per tap, since the line store has one read port and
// there is a single multiply-accumulate unit, then a rounding step and the
// wait on out_stall. The line store needs no clearing pass. The user must
// write configuration only while the block is idle; the block itself does
// not enforce this.
module vertical_gaussian_clamped_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [vgcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vgcf_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [vgcf_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vgcf_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [vgcf_pkg::ROW_W-1:0]         out_row,
  output logic [vgcf_pkg::COL_W-1:0]         out_col,
  output logic                               out_last_of_run,
  output logic                               out_last_of_frame
);

  vgcf_pkg::cmd_t    cmd;
  vgcf_pkg::status_t sts;

  // Sequencer.
  vgcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath.
  vgcf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_pixel_in       (in_pixel_in),
    .cmd               (cmd),
    .sts               (sts),
    .out_pixel_out     (out_pixel_out),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_frame (out_last_of_frame)
  );

  `include "vertical_gaussian_clamped_filter_assert.svh"

  // A new word is only taken when no result is on offer.
  `VGCF_ASSERT_SAME(a_idle_no_out, !in_stall, !out_valid)
  // The end of the frame is always the end of a run.
  `VGCF_ASSERT_SAME(a_frame_end_run, out_valid && out_last_of_frame, out_last_of_run)
  // After the last word of a run is taken, no further result follows at once.
  `VGCF_ASSERT_NEXT(a_run_closes, out_valid && !out_stall && out_last_of_run, !out_valid)

endmodule

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// Testbench for the vertical Gaussian filter
// Drives pixel words through directed and random frames and checks every
// filtered word against a cycle-free predictor of the clamped vertical blur.
// ---------------------------------------------------------------------------
module tb;

  localparam int WATCH_LIMIT = 5000;
  localparam int SETTLE      = 40;
  localparam int HOLD_LEN    = 400;

  typedef struct packed {
    logic [vgcf_pkg::PIX_W-1:0] pix;
    logic [vgcf_pkg::ROW_W-1:0] row;
    logic [vgcf_pkg::COL_W-1:0] col;
    logic                       last_run;
    logic                       last_frame;
  } blur_word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [vgcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vgcf_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [vgcf_pkg::PIX_W-1:0]     in_pixel_in = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [vgcf_pkg::PIX_W-1:0]     out_pixel_out;
  logic [vgcf_pkg::ROW_W-1:0]     out_row;
  logic [vgcf_pkg::COL_W-1:0]     out_col;
  logic                           out_last_of_run;
  logic                           out_last_of_frame;

  vertical_gaussian_clamped_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .out_row(out_row), .out_col(out_col), .out_last_of_run(out_last_of_run),
    .out_last_of_frame(out_last_of_frame)
  );

  always #2 clk = ~clk;

  // Predictor state: its own copy of the rows and the registers.
  logic [vgcf_pkg::PIX_W-1:0] row_mem [0:vgcf_pkg::STORE_DEPTH-1];
  int unsigned                col_pos, row_pos;
  int unsigned                width_reg, height_reg, span_reg;
  logic [63:0]                coef_reg [3];
  blur_word_t                 blur_q[$];

  int     err_cnt, words_sent, words_seen, frames_done;
  bit     idle_on = 1'b1;
  longint cyc;
  longint hold_until;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic int unsigned tap_coef(int unsigned k);
    logic [63:0] r;
    r = coef_reg[(k / 4) % 3];
    return 32'((r >> (16 * (k % 4))) & 64'hFFFF);
  endfunction

  function automatic longint unsigned row_pix(int unsigned r, int unsigned c);
    return row_mem[(r % vgcf_pkg::SLOTS) * vgcf_pkg::MAX_WIDTH + (c % vgcf_pkg::MAX_WIDTH)];
  endfunction

  // One blurred word for output row o, with row bot the last one known.
  function automatic logic [vgcf_pkg::PIX_W-1:0] blur_at(int unsigned o, int unsigned bot,
                                                        int unsigned c, int unsigned sp);
    longint unsigned acc;
    int unsigned     up, dn;
    acc = row_pix(o, c) * tap_coef(0);
    for (int unsigned k = 1; k <= sp; k++) begin
      up = (o >= k) ? o - k : 0;
      dn = (o + k <= bot) ? o + k : bot;
      acc += (row_pix(up, c) + row_pix(dn, c)) * tap_coef(k);
    end
    acc = (acc + 16384) >> 15;
    return (acc > 65535) ? 16'hFFFF : acc[15:0];
  endfunction

  // Store the accepted pixel and queue the words it releases.
  function automatic void blur_predict(logic [vgcf_pkg::PIX_W-1:0] p);
    int unsigned w, h, sp, y, c, first;
    blur_word_t  e;
    w  = (width_reg < 1) ? 1 :
         (width_reg > vgcf_pkg::MAX_WIDTH ? vgcf_pkg::MAX_WIDTH : width_reg);
    h  = (height_reg < 1) ? 1 : height_reg;
    sp = (span_reg > vgcf_pkg::MAX_SPAN) ? vgcf_pkg::MAX_SPAN : span_reg;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    y = row_pos;
    c = col_pos;
    row_mem[(y % vgcf_pkg::SLOTS) * vgcf_pkg::MAX_WIDTH + c] = p;
    if (y + 1 == h) begin
      first = (y >= sp) ? y - sp : 0;
      for (int unsigned o = first; o <= y; o++) begin
        e.pix        = blur_at(o, y, c, sp);
        e.row        = o[15:0];
        e.col        = c[10:0];
        e.last_run   = (o == y);
        e.last_frame = (o == y) && (c + 1 == w);
        blur_q.push_back(e);
      end
    end else if (y >= sp) begin
      e.pix        = blur_at(y - sp, y, c, sp);
      e.row        = 16'(y - sp);
      e.col        = c[10:0];
      e.last_run   = 1'b1;
      e.last_frame = 1'b0;
      blur_q.push_back(e);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= h) begin
        row_pos = 0;
        frames_done++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_cnt++;
  endtask

  // Result side: random stall, a long hold on request, and the word check.
  always @(posedge clk) begin
    blur_word_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (blur_q.size() == 0) begin
          report_mismatch("unexpected word, row", out_row, -1);
        end else begin
          e = blur_q.pop_front();
          if (out_pixel_out !== e.pix) report_mismatch("pixel_out", out_pixel_out, e.pix);
          if (out_row !== e.row) report_mismatch("out_row", out_row, e.row);
          if (out_col !== e.col) report_mismatch("out_col", out_col, e.col);
          if (out_last_of_run !== e.last_run)
            report_mismatch("last_of_run", out_last_of_run, e.last_run);
          if (out_last_of_frame !== e.last_frame)
            report_mismatch("last_of_frame", out_last_of_frame, e.last_frame);
        end
      end
      out_stall <= (cyc < hold_until) || (idle_on && $urandom_range(99) < 8);
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d words pending", blur_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one pixel word and wait for it to be taken.
  task automatic send_word(logic [vgcf_pkg::PIX_W-1:0] p);
    if (idle_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= p;
    do @(posedge clk); while (in_stall);
    words_sent++;
    blur_predict(p);
  endtask

  // Stop sending and wait until every queued word has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [vgcf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      vgcf_pkg::REG_WIDTH:  width_reg   = val[11:0];
      vgcf_pkg::REG_HEIGHT: height_reg  = val[15:0];
      vgcf_pkg::REG_SPAN:   span_reg    = val[3:0];
      vgcf_pkg::REG_COEF0:  coef_reg[0] = val;
      vgcf_pkg::REG_COEF1:  coef_reg[1] = val;
      vgcf_pkg::REG_COEF2:  coef_reg[2] = val;
      default: ;
    endcase
  endtask

  task automatic setup(int w, int h, int s, logic [63:0] c0, logic [63:0] c1,
                       logic [63:0] c2);
    write_reg(vgcf_pkg::REG_WIDTH, 64'(w));
    write_reg(vgcf_pkg::REG_HEIGHT, 64'(h));
    write_reg(vgcf_pkg::REG_SPAN, 64'(s));
    write_reg(vgcf_pkg::REG_COEF0, c0);
    write_reg(vgcf_pkg::REG_COEF1, c1);
    write_reg(vgcf_pkg::REG_COEF2, c2);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly modest Gaussian-like taps, sometimes fully random ones.
  function automatic logic [63:0] rand_coefs();
    logic [63:0] v;
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 4; i++) v[16*i +: 16] = 16'($urandom_range(0, 9000));
    return v;
  endfunction

  // Span wider than the frame: early rows and the short-frame flush.
  task automatic test_short_frame;
    setup(3, 2, 4, 64'h0800_1000_2000_4000, 64'h0100_0200_0300_0400,
          64'h0010_0020_0030_0040);
    for (int i = 0; i < 6; i++) send_word(16'($urandom));
    drain();
  endtask

  // Field extremes: black, white, saturation, span zero and span clamped.
  task automatic test_extremes;
    setup(2, 3, 0, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1);
    send_word(16'h0000); send_word(16'hFFFF);
    send_word(16'h0001); send_word(16'h8000);
    send_word(16'hFFFF); send_word(16'h7FFF);
    drain();
    setup(1, 1, 15, 64'h0000_0000_0000_8000, '1, '1);
    send_word(16'hFFFF); send_word(16'h5555); send_word(16'hAAAA);
    drain();
    setup(0, 0, 2, 64'hFFFF_0000_0000_7FFF, '0, '0);
    send_word(16'hFFFF); send_word(16'h1234);
    drain();
  endtask

  // Sizes changed inside a frame: counters past the new width and height.
  task automatic test_resize;
    setup(4095, 1, 1, 64'h0000_0000_2000_4000, '0, '0);
    for (int i = 0; i < 6; i++) send_word(16'($urandom));
    drain();
    setup(3, 1, 1, 64'h0000_0000_2000_4000, '0, '0);
    for (int i = 0; i < 3; i++) send_word(16'($urandom));
    drain();
    setup(2, 65535, 2, 64'h0000_1000_2000_4000, '0, '0);
    for (int i = 0; i < 9; i++) send_word(16'($urandom));
    drain();
    setup(2, 2, 2, 64'h0000_1000_2000_4000, '0, '0);
    for (int i = 0; i < 4; i++) send_word(16'($urandom));
    drain();
  endtask

  // The receiver holds off while the sender keeps offering words.
  task automatic test_backpressure;
    setup(2, 6, 1, 64'h0000_0000_2000_4000, '0, '0);
    @(posedge clk);
    hold_until <= cyc + HOLD_LEN;
    for (int i = 0; i < 12; i++) send_word(16'($urandom));
    drain();
  endtask

  // Random whole frames under random sizes, spans and taps.
  task automatic test_random;
    int w, h, s, n, nf;
    n = 0;
    for (int ph = 0; n < 200; ph++) begin
      idle_on = (ph % 5) != 2;
      s = ($urandom_range(7) == 0) ? 11 : $urandom_range(0, 15);
      w = $urandom_range(1, 5);
      h = (s == 11) ? 24 / w + 1 : $urandom_range(1, 40 / w);
      nf = $urandom_range(1, 2);
      setup(w, h, s, rand_coefs(), rand_coefs(), rand_coefs());
      for (int f = 0; f < nf; f++)
        for (int i = 0; i < w * h; i++) begin
          send_word(($urandom_range(9) == 0) ? {16{1'($urandom_range(1))}}
                                             : 16'($urandom));
          n++;
        end
      drain();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    hold_until = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frame();
    test_extremes();
    test_resize();
    test_backpressure();
    test_random();
    drain();
    $display("covered %0d pixel words, %0d filtered words, %0d whole frames",
             words_sent, words_seen, frames_done);
    $display("spans 0 to 15, widths 1 to 4095, heights 0 to 65535, one long output hold");
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/vgcf_pkg.sv
design/vgcf_ram.sv
design/vgcf_ctrl.sv
design/vgcf_datapath.sv
design/vertical_gaussian_clamped_filter.sv
sim/tb.sv
